// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge outside reset.
`define ARBP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every rising clock edge, during reset too.
`define ARBP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ARBP_ASSERT(label, clk, rst, prop)
`define ARBP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/arbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Auto-range brake to PWM package
// Shared constants and state types for the auto-ranging brake light block.
// ----------------------------------------------------------------------------
`default_nettype none

package arbp_pkg;

   // Default field widths.
   localparam int SAMPLE_BITS_DEF = 8;
   localparam int PWM_BITS_DEF    = 10;

   // Reset value of the full scale register, masked to the PWM width.
   localparam int FULL_SCALE_RESET = 1023;

   // Sequencer of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCALE,
      ST_SUM,
      ST_EMIT
   } arbp_state_type;

   // Sequencer of the serial scaling unit.
   typedef enum logic [1:0] {
      U_IDLE,
      U_MUL,
      U_DIV
   } arbp_unit_state_type;

endpackage : arbp_pkg

`default_nettype wire

// ===== rtl/arbp_req_if.sv =====
// ----------------------------------------------------------------------------
// Brake reading channel
// Valid/ready channel that carries one pair of brake sensor readings per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface arbp_req_if #(
   parameter int SAMPLE_BITS = arbp_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] brake_front;
   logic [SAMPLE_BITS-1:0] brake_rear;

   modport source (output valid, output brake_front, output brake_rear, input ready);
   modport sink   (input valid, input brake_front, input brake_rear, output ready);
endinterface : arbp_req_if

`default_nettype wire

// ===== rtl/arbp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// PWM duty channel
// Valid/ready channel that carries one PWM compare value per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface arbp_rsp_if #(
   parameter int PWM_BITS = arbp_pkg::PWM_BITS_DEF
);
   logic                valid;
   logic                ready;
   logic [PWM_BITS-1:0] pwm_duty;
   logic                duty_saturated;

   modport source (output valid, output pwm_duty, output duty_saturated, input ready);
   modport sink   (input valid, input pwm_duty, input duty_saturated, output ready);
endinterface : arbp_rsp_if

`default_nettype wire

// ===== rtl/arbp_serial_scale.sv =====
// ----------------------------------------------------------------------------
// Serial scaling unit
// Computes diff * full_scale / range with a bit-serial shift-add multiply
// followed by a bit-serial restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arbp_serial_scale #(
   parameter int SAMPLE_BITS = arbp_pkg::SAMPLE_BITS_DEF,
   parameter int PWM_BITS    = arbp_pkg::PWM_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SAMPLE_BITS-1:0] diff,
   input  wire logic [SAMPLE_BITS-1:0] range,
   input  wire logic [PWM_BITS-1:0]    full_scale,
   output logic                        busy,
   output logic [PWM_BITS-1:0]         quotient
);

   localparam int NUM_BITS = SAMPLE_BITS + PWM_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS);

   arbp_pkg::arbp_unit_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [NUM_BITS-1:0]    acc_ff, acc_in;
   logic [PWM_BITS-1:0]    mult_ff, mult_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;

   logic [SAMPLE_BITS:0]   trial;
   logic                   fits;

   // One restoring division step: bring down the next numerator bit.
   assign trial = {rem_ff, acc_ff[NUM_BITS-1]};
   assign fits  = (trial >= {1'b0, range});

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arbp_pkg::U_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mult_ff <= mult_in;
      rem_ff  <= rem_in;
   end

   // Sequencer: PWM_BITS multiply steps, then NUM_BITS divide steps.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mult_in  = mult_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         arbp_pkg::U_IDLE: begin
            if (start) begin
               acc_in   = '0;
               mult_in  = full_scale;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = arbp_pkg::U_MUL;
            end
         end
         arbp_pkg::U_MUL: begin
            // Multiplier bits are taken from the most significant end.
            acc_in  = {acc_ff[NUM_BITS-2:0], 1'b0}
                    + (mult_ff[PWM_BITS-1] ? NUM_BITS'(diff) : '0);
            mult_in = {mult_ff[PWM_BITS-2:0], 1'b0};
            if (cnt_ff == CNT_BITS'(PWM_BITS - 1)) begin
               cnt_in   = '0;
               state_in = arbp_pkg::U_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         arbp_pkg::U_DIV: begin
            // The numerator shifts out at the top as quotient bits enter below.
            rem_in = fits ? SAMPLE_BITS'(trial - {1'b0, range}) : trial[SAMPLE_BITS-1:0];
            acc_in = {acc_ff[NUM_BITS-2:0], fits};
            if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
               cnt_in   = '0;
               state_in = arbp_pkg::U_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = arbp_pkg::U_IDLE;
         end
      endcase
   end

   assign busy     = (state_ff != arbp_pkg::U_IDLE);
   assign quotient = acc_ff[PWM_BITS-1:0];

endmodule : arbp_serial_scale

`default_nettype wire

// ===== rtl/auto_range_brake_to_pwm_top.sv =====
// ----------------------------------------------------------------------------
// Auto-ranging brake light PWM
// Scales two brake sensor readings into their observed ranges and combines
// them into a saturated PWM compare value.
// ----------------------------------------------------------------------------
// Usage:
// The req_ch channel takes one item per sensor tick: a front and a rear raw
// reading. The rsp_ch channel gives exactly one item per accepted reading,
// the PWM duty and a flag set when the duty was clipped to full scale.
// The csr port writes the full scale register; write it only while idle.
// Each channel's minimum and maximum are updated first, then both channels
// are scaled in parallel by two serial multiply/divide units, one bit a
// cycle: PWM_BITS multiply steps followed by SAMPLE_BITS + PWM_BITS divide
// steps. An item passes through set-up, scaling, sum and output in turn
// before the block takes the next reading; the result is offered in the
// same cycle that the block is ready again.
// Reset sets full scale to 1023 and every channel's range to 128..129.
// A finished item waits in the output register while the next reading is
// taken in and worked on; if it is still waiting when the next result is
// ready, the block holds that result and accepts nothing further.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module auto_range_brake_to_pwm_top #(
   parameter int SAMPLE_BITS = arbp_pkg::SAMPLE_BITS_DEF,
   parameter int PWM_BITS    = arbp_pkg::PWM_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   arbp_req_if.sink                 req_ch,
   arbp_rsp_if.source               rsp_ch,
   input  wire logic                csr_wr_en,
   input  wire logic [PWM_BITS-1:0] csr_wr_data
);

   localparam logic [SAMPLE_BITS-1:0] MIN_RESET = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] MAX_RESET = MIN_RESET + SAMPLE_BITS'(1);
   localparam logic [PWM_BITS-1:0]    FS_RESET  = PWM_BITS'(arbp_pkg::FULL_SCALE_RESET);

   arbp_pkg::arbp_state_type state_ff, state_in;

   logic [PWM_BITS-1:0]    fs_ff;
   logic [SAMPLE_BITS-1:0] reading_ff [2];
   logic [SAMPLE_BITS-1:0] min_ff     [2];
   logic [SAMPLE_BITS-1:0] max_ff     [2];
   logic [SAMPLE_BITS-1:0] diff_ff    [2];
   logic [SAMPLE_BITS-1:0] range_ff   [2];
   logic [PWM_BITS:0]      sum_ff;
   logic                   rsp_valid_ff;
   logic [PWM_BITS-1:0]    rsp_duty_ff;
   logic                   rsp_sat_ff;

   logic                   accept;
   logic                   unit_start;
   logic                   emit;
   logic [1:0]             unit_busy;
   logic [PWM_BITS-1:0]    scaled [2];
   logic [PWM_BITS+1:0]    front_x3;
   logic [SAMPLE_BITS-1:0] new_reading [2];
   logic [SAMPLE_BITS-1:0] span [2];
   logic                   clip;

   assign accept         = req_ch.valid && req_ch.ready;
   assign new_reading[0] = req_ch.brake_front;
   assign new_reading[1] = req_ch.brake_rear;

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake outputs.
   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      unit_start   = 1'b0;
      emit         = 1'b0;
      unique case (state_ff)
         arbp_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = arbp_pkg::ST_START;
            end
         end
         arbp_pkg::ST_START: begin
            unit_start = 1'b1;
            state_in   = arbp_pkg::ST_SCALE;
         end
         arbp_pkg::ST_SCALE: begin
            if (unit_busy == 2'b00) begin
               state_in = arbp_pkg::ST_SUM;
            end
         end
         arbp_pkg::ST_SUM: begin
            state_in = arbp_pkg::ST_EMIT;
         end
         arbp_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               emit     = 1'b1;
               state_in = arbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arbp_pkg::ST_IDLE;
         end
      endcase
   end

   // Full scale register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= FS_RESET;
      end else if (csr_wr_en) begin
         fs_ff <= csr_wr_data;
      end
   end

   // Per-channel range tracking, updated with the reading as it is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff[0] <= MIN_RESET;
         min_ff[1] <= MIN_RESET;
         max_ff[0] <= MAX_RESET;
         max_ff[1] <= MAX_RESET;
      end else if (accept) begin
         for (int ch = 0; ch < 2; ch++) begin
            if (new_reading[ch] < min_ff[ch]) begin
               min_ff[ch] <= new_reading[ch];
            end
            if (new_reading[ch] > max_ff[ch]) begin
               max_ff[ch] <= new_reading[ch];
            end
         end
      end
   end

   // Offset and span for the scaling units; a zero span divides by one.
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         span[ch] = max_ff[ch] - min_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         reading_ff[0] <= new_reading[0];
         reading_ff[1] <= new_reading[1];
      end
      if (state_ff == arbp_pkg::ST_START) begin
         for (int ch = 0; ch < 2; ch++) begin
            diff_ff[ch]  <= reading_ff[ch] - min_ff[ch];
            range_ff[ch] <= (span[ch] == '0) ? SAMPLE_BITS'(1) : span[ch];
         end
      end
   end

   // One serial scaling unit per channel.
   arbp_serial_scale #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PWM_BITS    (PWM_BITS)
   ) u_scale_front (
      .clock      (clock),
      .reset      (reset),
      .start      (unit_start),
      .diff       (diff_ff[0]),
      .range      (range_ff[0]),
      .full_scale (fs_ff),
      .busy       (unit_busy[0]),
      .quotient   (scaled[0])
   );

   arbp_serial_scale #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PWM_BITS    (PWM_BITS)
   ) u_scale_rear (
      .clock      (clock),
      .reset      (reset),
      .start      (unit_start),
      .diff       (diff_ff[1]),
      .range      (range_ff[1]),
      .full_scale (fs_ff),
      .busy       (unit_busy[1]),
      .quotient   (scaled[1])
   );

   // Front weighted by three quarters, plus rear.
   assign front_x3 = {scaled[0], 1'b0} + (PWM_BITS + 2)'(scaled[0]);

   always_ff @(posedge clock) begin
      if (state_ff == arbp_pkg::ST_SUM) begin
         sum_ff <= (PWM_BITS + 1)'(front_x3[PWM_BITS+1:2]) + (PWM_BITS + 1)'(scaled[1]);
      end
   end

   // Saturation and the output register.
   assign clip = (sum_ff > {1'b0, fs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_duty_ff <= clip ? fs_ff : sum_ff[PWM_BITS-1:0];
         rsp_sat_ff  <= clip;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pwm_duty       = rsp_duty_ff;
   assign rsp_ch.duty_saturated = rsp_sat_ff;

   // The tracked range of each channel never collapses.
   `ARBP_ASSERT(a_front_range, clock, reset, min_ff[0] < max_ff[0])
   `ARBP_ASSERT(a_rear_range, clock, reset, min_ff[1] < max_ff[1])
   // The scaling units only run while the sequencer waits on them.
   `ARBP_ASSERT(a_units_in_scale, clock, reset, (unit_busy != 2'b00) |-> (state_ff == arbp_pkg::ST_SCALE))
   // Both units are started together and finish together.
   `ARBP_ASSERT(a_units_lockstep, clock, reset, unit_busy[0] == unit_busy[1])
   // A clipped item carries exactly the full scale value.
   `ARBP_ASSERT(a_sat_full_scale, clock, reset, (rsp_valid_ff && rsp_sat_ff) |-> (rsp_duty_ff == fs_ff))

endmodule : auto_range_brake_to_pwm_top

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Auto-ranging brake light PWM testbench
// Sends pairs of brake readings through the request channel and checks every
// PWM duty item against a local model. The model tracks each channel's
// observed minimum and maximum, scales the readings into the full scale and
// combines them with clipping. Directed cases come first, then random
// readings under three sender and receiver idling patterns, with the full
// scale register changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb;

   localparam int SB = arbp_pkg::SAMPLE_BITS_DEF;
   localparam int PB = arbp_pkg::PWM_BITS_DEF;

   localparam logic [SB-1:0] READING_MAX = {SB{1'b1}};
   localparam logic [SB-1:0] LOW_RESET   = SB'(1 << (SB - 1));
   localparam logic [SB-1:0] HIGH_RESET  = LOW_RESET + 1'b1;
   localparam logic [PB-1:0] SCALE_MAX   = {PB{1'b1}};

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TAIL_CYCLES   = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [PB-1:0] duty;
      logic          saturated;
   } duty_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic          csr_wr_en;
   logic [PB-1:0] csr_wr_data;

   arbp_req_if #(.SAMPLE_BITS(SB)) req_ch ();
   arbp_rsp_if #(.PWM_BITS(PB))    rsp_ch ();

   auto_range_brake_to_pwm_top #(
      .SAMPLE_BITS(SB),
      .PWM_BITS   (PB)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Model state: full scale and the observed range of each channel.
   logic [PB-1:0] full_scale_q   = PB'(arbp_pkg::FULL_SCALE_RESET);
   logic [SB-1:0] range_low [2]  = '{LOW_RESET, LOW_RESET};
   logic [SB-1:0] range_high [2] = '{HIGH_RESET, HIGH_RESET};

   duty_result_type expected_duty_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;
   int failures      = 0;
   int reports       = 0;
   int readings_sent = 0;
   int duties_seen   = 0;
   int duties_clipped = 0;
   int scale_writes  = 0;

   always #5 clock = ~clock;

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d duty items outstanding.",
                  cycle_count, expected_duty_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Records a failure; only the first few are printed.
   task automatic note_failure(input string msg);
      failures++;
      if (reports < REPORT_LIMIT) begin
         reports++;
         $display("[%0t] %s", $time, msg);
      end
   endtask

   // Widens one channel's range with the reading, then scales it into 0..full scale.
   function automatic int unsigned scale_reading(input int ch, input logic [SB-1:0] reading);
      int unsigned span;
      if (reading < range_low[ch]) range_low[ch] = reading;
      if (reading > range_high[ch]) range_high[ch] = reading;
      span = (range_high[ch] > range_low[ch]) ? 32'(range_high[ch] - range_low[ch]) : 32'd1;
      return ((int'(reading) - int'(range_low[ch])) * int'(full_scale_q)) / span;
   endfunction

   // Duty for one pair of readings: three quarters of front plus rear, clipped.
   function automatic duty_result_type compute_brake_duty(input logic [SB-1:0] front,
                                                          input logic [SB-1:0] rear);
      int unsigned     front_scaled;
      int unsigned     rear_scaled;
      int unsigned     combined;
      duty_result_type res;
      front_scaled  = scale_reading(0, front);
      rear_scaled   = scale_reading(1, rear);
      combined      = (front_scaled * 3) / 4 + rear_scaled;
      res.saturated = (combined > full_scale_q);
      if (res.saturated) combined = 32'(full_scale_q);
      res.duty = PB'(combined);
      return res;
   endfunction

   // Receiver: ready changes at the falling edge, idling at the set rate.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Checks each duty item against the oldest expectation.
   always @(posedge clock) begin : check_duty
      duty_result_type seen;
      duty_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.duty      = rsp_ch.pwm_duty;
         seen.saturated = rsp_ch.duty_saturated;
         if (expected_duty_q.size() == 0) begin
            note_failure($sformatf("unexpected duty item: duty %0d clipped %0b",
                                   seen.duty, seen.saturated));
         end else begin
            want = expected_duty_q.pop_front();
            duties_seen++;
            if (want.saturated) duties_clipped++;
            if (seen !== want) begin
               note_failure($sformatf(
                  "duty mismatch: expected duty %0d clipped %0b, got duty %0d clipped %0b",
                  want.duty, want.saturated, seen.duty, seen.saturated));
            end
         end
      end
   end

   // Offers one reading pair, with random idle cycles first, and waits for acceptance.
   task automatic send_reading(input logic [SB-1:0] front, input logic [SB-1:0] rear);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.brake_front = front;
      req_ch.brake_rear  = rear;
      do @(posedge clock); while (!req_ch.ready);
      expected_duty_q.push_back(compute_brake_duty(front, rear));
      readings_sent++;
   endtask

   // Stops sending and waits until every duty item has come back.
   task automatic wait_for_all_duties();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_duty_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the full scale register once the block is idle.
   task automatic write_full_scale(input logic [PB-1:0] value);
      wait_for_all_duties();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      full_scale_q = value;
      scale_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [SB-1:0] pick_reading();
      unique case ($urandom_range(9))
         0: return '0;
         1: return READING_MAX;
         default: return SB'($urandom_range(int'(READING_MAX)));
      endcase
   endfunction

   // Readings inside the reset range of 128 to 129.
   task automatic test_reset_range();
      send_reading(LOW_RESET, LOW_RESET);
      send_reading(HIGH_RESET, HIGH_RESET);
      send_reading(LOW_RESET, HIGH_RESET);
      send_reading(HIGH_RESET, LOW_RESET);
   endtask

   // Readings that widen each range a little at a time.
   task automatic test_range_growth();
      send_reading(LOW_RESET + SB'(2), LOW_RESET - SB'(1));
      send_reading(LOW_RESET - SB'(1), LOW_RESET + SB'(2));
      send_reading(LOW_RESET + SB'(12), LOW_RESET - SB'(8));
      send_reading(LOW_RESET, LOW_RESET);
   endtask

   // Smallest and largest readings on each channel.
   task automatic test_field_extremes();
      send_reading('0, '0);
      send_reading(READING_MAX, READING_MAX);
      send_reading('0, READING_MAX);
      send_reading(READING_MAX, '0);
      send_reading(READING_MAX, LOW_RESET);
      send_reading(LOW_RESET, READING_MAX);
   endtask

   // Full scale of one, of zero and back to the largest.
   task automatic test_full_scale_extremes();
      write_full_scale(PB'(1));
      send_reading(READING_MAX, READING_MAX);
      send_reading('0, READING_MAX);
      send_reading(READING_MAX, '0);
      send_reading(LOW_RESET, LOW_RESET);
      write_full_scale('0);
      send_reading(READING_MAX, READING_MAX);
      send_reading(SB'(100), SB'(200));
      write_full_scale(SCALE_MAX);
      send_reading(SB'(200), SB'(50));
   endtask

   // Random readings in three blocks, each at its own full scale.
   task automatic test_random_readings(input int n_items, input int send_pct,
                                       input int recv_pct);
      int block_len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      block_len     = n_items / 3;
      for (int blk = 0; blk < 3; blk++) begin
         unique case (blk)
            0: write_full_scale(PB'($urandom_range(1, int'(SCALE_MAX))));
            1: write_full_scale(PB'($urandom_range(1, 15)));
            default: write_full_scale(PB'($urandom_range(int'(SCALE_MAX) - 23,
                                                         int'(SCALE_MAX))));
         endcase
         for (int i = 0; i < block_len; i++) begin
            // Let the pipeline run dry once, in the middle of the first block.
            if (blk == 0 && i == block_len / 2) wait_for_all_duties();
            send_reading(pick_reading(), pick_reading());
         end
      end
   endtask

   initial begin
      int drain_cycles;
      req_ch.valid       = 1'b0;
      req_ch.brake_front = '0;
      req_ch.brake_rear  = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      send_idle_pct      = 9;
      recv_idle_pct      = 45;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_range();
      test_range_growth();
      test_field_extremes();
      test_full_scale_extremes();
      test_random_readings(210, 9, 45);
      test_random_readings(210, 45, 9);
      test_random_readings(210, 0, 0);

      // Drain, then allow the block's latency before the final verdict.
      @(negedge clock);
      req_ch.valid = 1'b0;
      drain_cycles = 0;
      while (expected_duty_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_duty_q.size() != 0) begin
         note_failure($sformatf("%0d duty items never arrived", expected_duty_q.size()));
      end

      $display("Sent %0d brake reading pairs across %0d full scale settings;",
               readings_sent, scale_writes + 1);
      $display("checked %0d duty items, %0d of them clipped, with %0d failures.",
               duties_seen, duties_clipped, failures);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule : tb
